### rtl/core/gke_pkg.sv
// gke_pkg: shared types, constants and helpers of the group key element extractor
// no dependencies; used by the channel interfaces and by gtk_kde_extractor_top
package gke_pkg;

    // fixed field widths of the channels
    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 2;
    localparam int unsigned LEN_W       = 6;
    localparam int unsigned WORD_W      = 64;
    localparam int unsigned NUM_WORDS   = 4;
    localparam int unsigned WORD_BYTES  = WORD_W / BYTE_W;
    localparam int unsigned STORE_BYTES = NUM_WORDS * WORD_BYTES;

    // default key store size in bytes (1..STORE_BYTES)
    localparam int unsigned KEY_BYTES_DEF = 32;

    // element constants
    localparam logic [BYTE_W-1:0] TYPE_END    = 8'h00;
    localparam logic [BYTE_W-1:0] TYPE_VENDOR = 8'hDD;
    localparam logic [BYTE_W-1:0] OUI_0       = 8'h00;
    localparam logic [BYTE_W-1:0] OUI_1       = 8'h0F;
    localparam logic [BYTE_W-1:0] OUI_2       = 8'hAC;
    localparam logic [BYTE_W-1:0] DATA_GTK    = 8'h01;
    localparam logic [BYTE_W-1:0] INDEX_MASK  = 8'h03;
    localparam logic [BYTE_W-1:0] HDR_LEN     = 8'd6;
    localparam logic [BYTE_W-1:0] OFS_INDEX   = 8'd4;
    localparam logic [BYTE_W-1:0] OFS_TAG_END = 8'd4;

    typedef enum logic [1:0] {
        PH_TYPE,
        PH_LEN,
        PH_BODY,
        PH_STOP
    } t_phase;

    typedef struct packed {
        logic                             found;
        logic [INDEX_W-1:0]               key_index;
        logic [LEN_W-1:0]                 key_length;
        logic [NUM_WORDS-1:0][WORD_W-1:0] key_words;
    } t_key_result;

    // expected oui / data type byte at body offsets 0..3
    function automatic logic [BYTE_W-1:0] tag_byte(input logic [1:0] ofs);
        logic [BYTE_W-1:0] t;
        case (ofs)
            2'd0:    t = OUI_0;
            2'd1:    t = OUI_1;
            2'd2:    t = OUI_2;
            default: t = DATA_GTK;
        endcase
        return t;
    endfunction

endpackage

### rtl/core/gke_byte_if.sv
// gke_byte_if: valid/ready channel carrying one key-data byte per word
// depends on gke_pkg for field widths
interface gke_byte_if;
    logic                      valid;
    logic                      ready;
    logic [gke_pkg::BYTE_W-1:0] data_byte;
    logic                      last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

### rtl/core/gke_key_if.sv
// gke_key_if: valid/ready channel carrying one group key report per word
// depends on gke_pkg for field widths
interface gke_key_if;
    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [gke_pkg::INDEX_W-1:0] key_index;
    logic [gke_pkg::LEN_W-1:0]   key_length;
    logic [gke_pkg::WORD_W-1:0]  key_word_0;
    logic [gke_pkg::WORD_W-1:0]  key_word_1;
    logic [gke_pkg::WORD_W-1:0]  key_word_2;
    logic [gke_pkg::WORD_W-1:0]  key_word_3;

    modport source (output valid, output found, output key_index, output key_length,
                    output key_word_0, output key_word_1, output key_word_2,
                    output key_word_3, input ready);
    modport sink   (input valid, input found, input key_index, input key_length,
                    input key_word_0, input key_word_1, input key_word_2,
                    input key_word_3, output ready);
endinterface

### rtl/core/gtk_kde_extractor_top.sv
// gtk_kde_extractor_top: group key element extractor; uses gke_pkg and both channel ifs
// a last byte's report is registered into the output register, or into the skid register while the output stalls
// throughput: one byte per cycle, set by the single-pass parser step on each byte;
// output register plus skid stalls the input only while two reports wait
// reset (synchronous, active low) clears the parser, the found flag, the key store,
// key index and key length at once; no clearing pass
module gtk_kde_extractor_top #(
    parameter int unsigned KEY_BYTES = gke_pkg::KEY_BYTES_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    gke_byte_if.sink       i_byte_if,
    gke_key_if.source      o_key_if
);
    import gke_pkg::*;

    // ------------------------------------------------------------------
    // parser state
    // ------------------------------------------------------------------
    t_phase              r_phase,  n_phase;
    logic [BYTE_W-1:0]   r_offset, n_offset;   // position inside element body
    logic [BYTE_W-1:0]   r_type,   n_type;
    logic [BYTE_W-1:0]   r_length, n_length;
    logic                r_oui,    n_oui;      // oui and data type still match
    logic [INDEX_W-1:0]  r_cidx,   n_cidx;     // candidate key index
    logic                r_found,  n_found;    // committed in this sequence

    // candidate key bytes, written as the body streams in (no reset needed)
    logic [BYTE_W-1:0]   r_cand  [KEY_BYTES];
    // committed key store
    logic [BYTE_W-1:0]   r_store [KEY_BYTES];
    logic [BYTE_W-1:0]   n_store [KEY_BYTES];
    logic [INDEX_W-1:0]  r_sidx,   n_sidx;
    logic [LEN_W-1:0]    r_slen,   n_slen;

    // output stage
    logic                r_out_valid;
    t_key_result         r_out;
    logic                r_skid_valid;
    t_key_result         r_skid;

    // ------------------------------------------------------------------
    // handshake
    // ------------------------------------------------------------------
    logic        accept;
    logic        res_valid;
    logic        out_free;
    t_key_result res;

    logic [BYTE_W-1:0] in_byte;
    logic              in_last;

    assign in_byte = i_byte_if.data_byte;
    assign in_last = i_byte_if.last_byte;

    // only a full skid register stops the input
    assign i_byte_if.ready = !r_skid_valid;
    assign accept          = i_byte_if.valid && !r_skid_valid;
    assign res_valid       = accept && in_last;
    assign out_free        = !r_out_valid || o_key_if.ready;

    // ------------------------------------------------------------------
    // element decode
    // ------------------------------------------------------------------
    logic              body_done;   // this byte closes the element body
    logic              is_gtk;      // element qualifies as group key element
    logic              commit;
    logic              cand_wr;     // this byte is a key byte
    logic [BYTE_W-1:0] len_m6;
    logic [LEN_W-1:0]  key_len;

    assign body_done = ({1'b0, r_offset} + 9'd1) >= {1'b0, r_length};
    assign is_gtk    = (r_type == TYPE_VENDOR) && (r_length >= HDR_LEN) && r_oui;
    assign commit    = accept && (r_phase == PH_BODY) && body_done && is_gtk;
    assign cand_wr   = accept && (r_phase == PH_BODY) && (r_offset >= HDR_LEN);
    assign len_m6    = r_length - HDR_LEN;
    // key length clipped to the store size
    assign key_len   = (len_m6 > BYTE_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : LEN_W'(len_m6);

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (accept) begin
            case (r_phase)
                PH_TYPE: begin
                    n_phase = (in_byte == TYPE_END) ? PH_STOP : PH_LEN;
                end
                PH_LEN: begin
                    // zero length closes the element at once, never a key
                    n_phase = (in_byte == TYPE_END) ? PH_TYPE : PH_BODY;
                end
                PH_BODY: begin
                    if (body_done) begin
                        n_phase = is_gtk ? PH_STOP : PH_TYPE;
                    end
                end
                default: begin
                    n_phase = PH_STOP;
                end
            endcase
            // end of sequence restarts the walk
            if (in_last) begin
                n_phase = PH_TYPE;
            end
        end
    end

    // parser fields and key store
    always_comb begin
        n_type   = r_type;
        n_length = r_length;
        n_offset = r_offset;
        n_oui    = r_oui;
        n_cidx   = r_cidx;
        n_found  = r_found;
        n_sidx   = r_sidx;
        n_slen   = r_slen;

        if (accept) begin
            case (r_phase)
                PH_TYPE: begin
                    if (in_byte != TYPE_END) begin
                        n_type = in_byte;
                    end
                end
                PH_LEN: begin
                    n_length = in_byte;
                    n_offset = '0;
                    n_oui    = 1'b1;
                end
                PH_BODY: begin
                    if (r_offset < OFS_TAG_END) begin
                        if (in_byte != tag_byte(r_offset[1:0])) begin
                            n_oui = 1'b0;
                        end
                    end else if (r_offset == OFS_INDEX) begin
                        n_cidx = INDEX_W'(in_byte & INDEX_MASK);
                    end
                    if (!body_done) begin
                        n_offset = r_offset + 8'd1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (commit) begin
            n_found = 1'b1;
            n_sidx  = r_cidx;
            n_slen  = key_len;
        end

        // bytes past the new length keep their old value; the last key byte may
        // arrive on the committing cycle, so it bypasses the candidate register
        for (int i = 0; i < KEY_BYTES; i++) begin
            n_store[i] = r_store[i];
            if (commit && (LEN_W'(i) < key_len)) begin
                if (cand_wr && (r_offset == BYTE_W'(i + 6))) begin
                    n_store[i] = in_byte;
                end else begin
                    n_store[i] = r_cand[i];
                end
            end
        end
    end

    // report built from the state after this byte
    always_comb begin
        res.found      = n_found;
        res.key_index  = n_sidx;
        res.key_length = n_slen;
        res.key_words  = '0;
        for (int j = 0; j < STORE_BYTES; j++) begin
            if (j < KEY_BYTES) begin
                res.key_words[j / WORD_BYTES][(j % WORD_BYTES) * BYTE_W +: BYTE_W] =
                    n_store[j % KEY_BYTES];
            end
        end
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_offset <= '0;
            r_type   <= '0;
            r_length <= '0;
            r_oui    <= 1'b0;
            r_cidx   <= '0;
            r_found  <= 1'b0;
            r_sidx   <= '0;
            r_slen   <= '0;
            for (int i = 0; i < KEY_BYTES; i++) begin
                r_store[i] <= '0;
            end
        end else begin
            r_phase <= n_phase;
            r_sidx  <= n_sidx;
            r_slen  <= n_slen;
            r_store <= n_store;
            if (res_valid) begin
                // clear the per-sequence parse state
                r_offset <= '0;
                r_type   <= '0;
                r_length <= '0;
                r_oui    <= 1'b0;
                r_cidx   <= '0;
                r_found  <= 1'b0;
            end else begin
                r_offset <= n_offset;
                r_type   <= n_type;
                r_length <= n_length;
                r_oui    <= n_oui;
                r_cidx   <= n_cidx;
                r_found  <= n_found;
            end
        end
    end

    // candidate key bytes, one entry per key-byte offset in the body
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (cand_wr && (r_offset == BYTE_W'(i + 6))) begin
                r_cand[i] <= in_byte;
            end
        end
    end

    // output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (out_free) begin
                if (r_skid_valid) begin
                    r_out_valid  <= 1'b1;
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_valid;
                end
            end else if (res_valid) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skid_valid) begin
                r_out <= r_skid;
            end else if (res_valid) begin
                r_out <= res;
            end
        end else if (res_valid) begin
            r_skid <= res;
        end
    end

    assign o_key_if.valid      = r_out_valid;
    assign o_key_if.found      = r_out.found;
    assign o_key_if.key_index  = r_out.key_index;
    assign o_key_if.key_length = r_out.key_length;
    assign o_key_if.key_word_0 = r_out.key_words[0];
    assign o_key_if.key_word_1 = r_out.key_words[1];
    assign o_key_if.key_word_2 = r_out.key_words[2];
    assign o_key_if.key_word_3 = r_out.key_words[3];

endmodule
